>>> src/ltcm_pkg.sv
// Shared types, constants and helpers for the luminance tint color mapper.
package ltcm_pkg;

    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned LEVEL_W     = 11;
    localparam int unsigned SECTOR_W    = 3;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned LEVEL_SHIFT = 5;

    // Number of gray levels; higher indexes clamp to the last level.
    localparam logic [16:0] LEVEL_COUNT = 17'd2048;
    localparam logic [16:0] LEVEL_MAX   = LEVEL_COUNT - 17'd1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_FULL = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_HALF = 16'h7FFF;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_SECTOR    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_FRACTION  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TINT_STRENGTH = 2'd2;

    // Hue sector codes; codes six and seven alias sectors zero and one.
    localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA_RED   = 3'd5;
    localparam logic [SECTOR_W-1:0] SECTOR_WRAP_RED      = 3'd6;
    localparam logic [SECTOR_W-1:0] SECTOR_WRAP_YELLOW   = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] gray;
        logic [SAMPLE_W-1:0] sat;
        logic [SAMPLE_W-1:0] val;
    } t_sv_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] gray;
        logic [SAMPLE_W-1:0] val;
        logic [SAMPLE_W-1:0] p;
        logic [SAMPLE_W-1:0] q;
        logic [SAMPLE_W-1:0] t;
    } t_hsv_item;

    // 16x16 fractional multiply, upper half of the product.
    function automatic logic [SAMPLE_W-1:0] mul16(input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
        logic [2*SAMPLE_W-1:0] prod;
        prod = a * b;
        return prod[2*SAMPLE_W-1:SAMPLE_W];
    endfunction

endpackage

>>> src/ltcm_sv_gen.sv
// Stage 1: level to gray sample, then saturation and value of the tint.
module ltcm_sv_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ltcm_pkg::LEVEL_W-1:0] i_gray_level,
    output logic                        o_valid,
    output ltcm_pkg::t_sv_item          o_item
);
    import ltcm_pkg::*;

    logic [16:0]         level_ext;
    logic [16:0]         level_clamp;
    logic [21:0]         gray_wide;
    logic [SAMPLE_W-1:0] gray;
    logic [SAMPLE_W-1:0] inv;
    logic [SAMPLE_W-1:0] over;
    t_sv_item            n_item;
    t_sv_item            r_item;
    logic                r_valid;

    always_comb begin
        level_ext   = {{(17-LEVEL_W){1'b0}}, i_gray_level};
        level_clamp = (level_ext > LEVEL_MAX) ? LEVEL_MAX : level_ext;
        gray_wide   = {level_clamp, {LEVEL_SHIFT{1'b0}}};
        gray        = (gray_wide > {6'd0, SAMPLE_FULL}) ? SAMPLE_FULL
                                                        : gray_wide[SAMPLE_W-1:0];
        inv         = SAMPLE_FULL - gray;
        over        = inv - SAMPLE_HALF;
        n_item.gray = gray;
        if (inv < SAMPLE_HALF) begin
            n_item.sat = {inv[SAMPLE_W-2:0], 1'b0};
            n_item.val = SAMPLE_FULL;
        end else begin
            n_item.sat = SAMPLE_FULL;
            n_item.val = (inv == SAMPLE_FULL) ? '0
                                              : SAMPLE_FULL - {over[SAMPLE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/ltcm_hsv.sv
// Stages 2 and 3: fixed-point HSV products P, Q and T.
module ltcm_hsv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ltcm_pkg::SAMPLE_W-1:0] i_hue_fraction,
    input  logic                          i_valid,
    input  ltcm_pkg::t_sv_item            i_item,
    output logic                          o_valid,
    output ltcm_pkg::t_hsv_item           o_item
);
    import ltcm_pkg::*;

    // stage 2 registers
    logic                r_s2_valid;
    logic [SAMPLE_W-1:0] r_s2_gray;
    logic [SAMPLE_W-1:0] r_s2_val;
    logic [SAMPLE_W-1:0] r_s2_p;
    logic [SAMPLE_W-1:0] r_s2_sf;
    logic [SAMPLE_W-1:0] r_s2_sfn;
    // stage 3 registers
    logic                r_s3_valid;
    t_hsv_item           r_s3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_gray <= i_item.gray;
        r_s2_val  <= i_item.val;
        r_s2_p    <= mul16(i_item.val, SAMPLE_FULL - i_item.sat);
        r_s2_sf   <= mul16(i_item.sat, i_hue_fraction);
        r_s2_sfn  <= mul16(i_item.sat, SAMPLE_FULL - i_hue_fraction);

        r_s3_item.gray <= r_s2_gray;
        r_s3_item.val  <= r_s2_val;
        r_s3_item.p    <= r_s2_p;
        r_s3_item.q    <= mul16(r_s2_val, SAMPLE_FULL - r_s2_sf);
        r_s3_item.t    <= mul16(r_s2_val, SAMPLE_FULL - r_s2_sfn);
    end

    assign o_valid = r_s3_valid;
    assign o_item  = r_s3_item;

endmodule

>>> src/ltcm_blend.sv
// Stages 4 and 5: sector permutation and blend of each channel with the gray.
module ltcm_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ltcm_pkg::SECTOR_W-1:0] i_hue_sector,
    input  logic [ltcm_pkg::SAMPLE_W-1:0] i_tint_strength,
    input  logic                          i_valid,
    input  ltcm_pkg::t_hsv_item           i_item,
    output logic                          o_valid,
    output logic [ltcm_pkg::SAMPLE_W-1:0] o_red_out,
    output logic [ltcm_pkg::SAMPLE_W-1:0] o_green_out,
    output logic [ltcm_pkg::SAMPLE_W-1:0] o_blue_out
);
    import ltcm_pkg::*;

    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] keep;

    logic                r_s4_valid;
    logic [SAMPLE_W-1:0] r_s4_red;
    logic [SAMPLE_W-1:0] r_s4_green;
    logic [SAMPLE_W-1:0] r_s4_blue;
    logic [SAMPLE_W-1:0] r_s4_gray;

    logic                r_s5_valid;
    logic [SAMPLE_W-1:0] r_s5_red;
    logic [SAMPLE_W-1:0] r_s5_green;
    logic [SAMPLE_W-1:0] r_s5_blue;

    always_comb begin
        case (i_hue_sector) inside
            SECTOR_RED_YELLOW, SECTOR_WRAP_RED: begin
                red = i_item.val; green = i_item.t;   blue = i_item.p;
            end
            SECTOR_YELLOW_GREEN, SECTOR_WRAP_YELLOW: begin
                red = i_item.q;   green = i_item.val; blue = i_item.p;
            end
            SECTOR_GREEN_CYAN: begin
                red = i_item.p;   green = i_item.val; blue = i_item.t;
            end
            SECTOR_CYAN_BLUE: begin
                red = i_item.p;   green = i_item.q;   blue = i_item.val;
            end
            SECTOR_BLUE_MAGENTA: begin
                red = i_item.t;   green = i_item.p;   blue = i_item.val;
            end
            default: begin
                red = i_item.val; green = i_item.p;   blue = i_item.q;
            end
        endcase
        keep = SAMPLE_FULL - i_tint_strength;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s4_valid <= i_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // Sums wrap to 16 bits.
    always_ff @(posedge i_clk) begin
        r_s4_red   <= mul16(red, i_tint_strength);
        r_s4_green <= mul16(green, i_tint_strength);
        r_s4_blue  <= mul16(blue, i_tint_strength);
        r_s4_gray  <= mul16(i_item.gray, keep);

        r_s5_red   <= r_s4_red + r_s4_gray;
        r_s5_green <= r_s4_green + r_s4_gray;
        r_s5_blue  <= r_s4_blue + r_s4_gray;
    end

    assign o_valid     = r_s5_valid;
    assign o_red_out   = r_s5_red;
    assign o_green_out = r_s5_green;
    assign o_blue_out  = r_s5_blue;

endmodule

>>> src/luminance_tint_color_mapper_top.sv
// Top level of the luminance tint color mapper: config registers and pipeline.
//
// Maps an 11-bit gray level to a tinted 16-bit RGB triple. A five-stage
// pipeline takes one item every clock: busy is low whenever reset is
// released, so start may be held high continuously. An accepted item passes
// the input stage, the S*F products, the V products, the tint blend
// multiplies and the output sums, each behind its own register; its result
// then appears on o_red_out/o_green_out/o_blue_out with o_valid high for
// one cycle only; the receiver cannot hold it, so capture it on that cycle.
// Write the hue sector, hue fraction and tint strength registers only
// while no items are in flight; they are read live by the pipeline stages.
module luminance_tint_color_mapper_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ltcm_pkg::LEVEL_W-1:0]     i_gray_level,
    input  logic                             i_cfg_we,
    input  logic [ltcm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ltcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_valid,
    output logic [ltcm_pkg::SAMPLE_W-1:0]    o_red_out,
    output logic [ltcm_pkg::SAMPLE_W-1:0]    o_green_out,
    output logic [ltcm_pkg::SAMPLE_W-1:0]    o_blue_out
);
    import ltcm_pkg::*;

    logic [SECTOR_W-1:0] r_hue_sector;
    logic [SAMPLE_W-1:0] r_hue_fraction;
    logic [SAMPLE_W-1:0] r_tint_strength;

    logic      in_accept;
    logic      sv_valid;
    t_sv_item  sv_item;
    logic      hsv_valid;
    t_hsv_item hsv_item;

    // Hold off items only during reset.
    assign busy      = !i_rst_n;
    assign in_accept = start && !busy;

    // Config writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_sector    <= '0;
            r_hue_fraction  <= '0;
            r_tint_strength <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HUE_SECTOR:    r_hue_sector    <= i_cfg_data[SECTOR_W-1:0];
                CFG_HUE_FRACTION:  r_hue_fraction  <= i_cfg_data[SAMPLE_W-1:0];
                CFG_TINT_STRENGTH: r_tint_strength <= i_cfg_data[SAMPLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage 1: gray sample, saturation and value.
    ltcm_sv_gen u_sv_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_accept),
        .i_gray_level (i_gray_level),
        .o_valid      (sv_valid),
        .o_item       (sv_item)
    );

    // Stages 2-3: P, Q, T products.
    ltcm_hsv u_hsv (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hue_fraction (r_hue_fraction),
        .i_valid        (sv_valid),
        .i_item         (sv_item),
        .o_valid        (hsv_valid),
        .o_item         (hsv_item)
    );

    // Stages 4-5: permutation by sector, blend with gray, output register.
    ltcm_blend u_blend (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_hue_sector    (r_hue_sector),
        .i_tint_strength (r_tint_strength),
        .i_valid         (hsv_valid),
        .i_item          (hsv_item),
        .o_valid         (o_valid),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out)
    );

    // Every accepted item produces a result strobe on o_valid.
    a_latency_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> ##5 o_valid)
        else $error("accepted item did not produce a result after five cycles");

    // No result appears without a matching accepted item.
    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(in_accept, 5))
        else $error("result strobe without a matching accepted item");

    // With zero tint the channels match each other.
    a_zero_tint_gray : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_tint_strength == '0 && $past(r_tint_strength, 2) == '0)
            |-> (o_red_out == o_green_out) && (o_green_out == o_blue_out))
        else $error("zero tint produced unequal channels");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the luminance tint color mapper top level.
module tb_top;
    import ltcm_pkg::*;

    // Index 3 has no register behind it; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam int unsigned RUN_LIMIT    = 200000;
    localparam int unsigned TAIL_CYCLES  = 12;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned PHASE_ITEMS  = 45;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned STREAM_ITEMS = 40;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
    } t_rgb_sample;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [LEVEL_W-1:0]     i_gray_level = '0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   o_valid;
    logic [SAMPLE_W-1:0]    o_red_out;
    logic [SAMPLE_W-1:0]    o_green_out;
    logic [SAMPLE_W-1:0]    o_blue_out;

    // Register copies as the block should hold them, updated on accepted writes.
    logic [SECTOR_W-1:0]    sector_copy;
    logic [SAMPLE_W-1:0]    fraction_copy;
    logic [SAMPLE_W-1:0]    strength_copy;

    t_rgb_sample            tint_expect_q[$];
    t_rgb_sample            tint_want;
    t_rgb_sample            tint_got;
    int unsigned            fail_count = 0;
    int unsigned            cycle_count = 0;
    int unsigned            idle_odds = 0;

    luminance_tint_color_mapper_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_gray_level(i_gray_level),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    always #2 i_clk = ~i_clk;

    // Upper half of a 16x16 product: a times b as fractions of one.
    function automatic logic [SAMPLE_W-1:0] frac_mul(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
        logic [2*SAMPLE_W-1:0] prod;
        prod = {16'd0, a} * {16'd0, b};
        return prod[2*SAMPLE_W-1:SAMPLE_W];
    endfunction

    // Expected tinted triple for one gray level under the given register values.
    function automatic t_rgb_sample predict_tint(input logic [LEVEL_W-1:0]  level,
                                                 input logic [SECTOR_W-1:0] sector,
                                                 input logic [SAMPLE_W-1:0] fraction,
                                                 input logic [SAMPLE_W-1:0] strength);
        logic [16:0]         idx;
        logic [31:0]         gray_wide;
        logic [SAMPLE_W-1:0] gray, inv, sat, val, p, q, t, keep, gray_part;
        logic [SAMPLE_W-1:0] ch_r, ch_g, ch_b;
        logic [SECTOR_W-1:0] sec;
        t_rgb_sample         res;
        // Clamp the level, then scale by 32 and clamp the sample to 16 bits.
        idx = {6'd0, level};
        if (idx > LEVEL_MAX)
            idx = LEVEL_MAX;
        gray_wide = {15'd0, idx} << LEVEL_SHIFT;
        if (gray_wide > {16'd0, SAMPLE_FULL})
            gray_wide = {16'd0, SAMPLE_FULL};
        gray = gray_wide[SAMPLE_W-1:0];
        inv  = SAMPLE_FULL - gray;
        // Dark half of the inverted range ramps saturation, bright half ramps value down.
        if (inv < SAMPLE_HALF) begin
            sat = inv << 1;
            val = SAMPLE_FULL;
        end else begin
            sat = SAMPLE_FULL;
            val = (inv == SAMPLE_FULL) ? '0 : SAMPLE_FULL - ((inv - SAMPLE_HALF) << 1);
        end
        p = frac_mul(val, SAMPLE_FULL - sat);
        q = frac_mul(val, SAMPLE_FULL - frac_mul(sat, fraction));
        t = frac_mul(val, SAMPLE_FULL - frac_mul(sat, SAMPLE_FULL - fraction));
        // Sector codes six and seven fold back onto zero and one.
        sec = (sector >= SECTOR_WRAP_RED) ? sector - SECTOR_WRAP_RED : sector;
        case (sec)
            SECTOR_RED_YELLOW: begin
                ch_r = val; ch_g = t;   ch_b = p;
            end
            SECTOR_YELLOW_GREEN: begin
                ch_r = q;   ch_g = val; ch_b = p;
            end
            SECTOR_GREEN_CYAN: begin
                ch_r = p;   ch_g = val; ch_b = t;
            end
            SECTOR_CYAN_BLUE: begin
                ch_r = p;   ch_g = q;   ch_b = val;
            end
            SECTOR_BLUE_MAGENTA: begin
                ch_r = t;   ch_g = p;   ch_b = val;
            end
            default: begin
                ch_r = val; ch_g = p;   ch_b = q;
            end
        endcase
        // Blend each channel with the gray; the sum wraps at 16 bits.
        keep      = SAMPLE_FULL - strength;
        gray_part = frac_mul(gray, keep);
        res.red   = frac_mul(ch_r, strength) + gray_part;
        res.green = frac_mul(ch_g, strength) + gray_part;
        res.blue  = frac_mul(ch_b, strength) + gray_part;
        return res;
    endfunction

    task automatic note_failure(input string what, input t_rgb_sample want,
                                input t_rgb_sample got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0d] %s: want r=%h g=%h b=%h, got r=%h g=%h b=%h", cycle_count,
                     what, want.red, want.green, want.blue, got.red, got.green, got.blue);
    endtask

    // Checker, predictor and register copies share one block so that a result
    // is matched before a same-edge item is queued.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sector_copy   <= '0;
            fraction_copy <= '0;
            strength_copy <= '0;
        end else begin
            if (o_valid === 1'b1) begin
                tint_got = '{o_red_out, o_green_out, o_blue_out};
                if (tint_expect_q.size() == 0) begin
                    note_failure("result with nothing pending", '0, tint_got);
                end else begin
                    tint_want = tint_expect_q.pop_front();
                    if (tint_got.red !== tint_want.red || tint_got.green !== tint_want.green
                            || tint_got.blue !== tint_want.blue)
                        note_failure("tint mismatch", tint_want, tint_got);
                end
            end
            if (start && busy === 1'b0)
                tint_expect_q.push_back(predict_tint(i_gray_level, sector_copy,
                                                     fraction_copy, strength_copy));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_HUE_SECTOR:    sector_copy   <= i_cfg_data[SECTOR_W-1:0];
                    CFG_HUE_FRACTION:  fraction_copy <= i_cfg_data;
                    CFG_TINT_STRENGTH: strength_copy <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: a hung pipeline or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("** luminance_tint_color_mapper_top: FAILED **");
            $finish;
        end
    end

    // Offer one item, with an optional random gap first; return at the
    // falling edge after it was taken, start still high.
    task automatic send_item(input logic [LEVEL_W-1:0] level);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_gray_level <= level;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (tint_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Write all registers on an empty pipeline, plus a write to the spare index.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] sector_word,
                                input logic [SAMPLE_W-1:0]   fraction,
                                input logic [SAMPLE_W-1:0]   strength);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HUE_SECTOR;
        i_cfg_data  <= sector_word;
        @(negedge i_clk);
        i_cfg_index <= CFG_HUE_FRACTION;
        i_cfg_data  <= fraction;
        @(negedge i_clk);
        i_cfg_index <= CFG_TINT_STRENGTH;
        i_cfg_data  <= strength;
        @(negedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return SAMPLE_FULL;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Bias toward the ends of the range and the saturation/value crossover.
    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return LEVEL_W'($urandom_range(1020, 1028));
            default: return LEVEL_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Registers are all zero after reset: output is plain gray.
    task automatic test_reset_state();
        send_item('0);
        send_item('1);
        send_item(LEVEL_W'(1536));
    endtask

    // Level ends and both sides of the point where saturation turns into value.
    task automatic test_level_extremes();
        program_regs({13'd0, SECTOR_RED_YELLOW}, 16'h8000, SAMPLE_FULL);
        send_item('0);
        send_item(LEVEL_W'(1023));
        send_item(LEVEL_W'(1024));
        send_item(LEVEL_W'(1025));
        send_item('1);
    endtask

    // Every sector code, six and seven included, with junk in the unused data bits.
    task automatic test_sector_map();
        logic [CFG_DATA_W-1:0] word;
        for (int s = 0; s < 8; s++) begin
            word = CFG_DATA_W'($urandom);
            word[SECTOR_W-1:0] = SECTOR_W'(s);
            program_regs(word, 16'h5A5A, 16'hC000);
            send_item(LEVEL_W'(1536));
        end
    endtask

    // Fraction and strength at both ends.
    task automatic test_blend_extremes();
        for (int f = 0; f < 2; f++) begin
            for (int a = 0; a < 2; a++) begin
                program_regs({13'd0, SECTOR_CYAN_BLUE}, f ? SAMPLE_FULL : '0,
                             a ? SAMPLE_FULL : '0);
                send_item(LEVEL_W'(700));
                send_item(LEVEL_W'(1800));
            end
        end
    endtask

    // Random register settings, each followed by a burst of random levels, with gaps in most phases.
    task automatic test_random_phases();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            program_regs(CFG_DATA_W'($urandom), pick_word(), pick_word());
            idle_odds = (ph % 3 == 2) ? 0 : $urandom_range(2, 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_level());
        end
    endtask

    // Closing stretch: one item every clock, no gaps.
    task automatic test_back_to_back();
        program_regs(CFG_DATA_W'($urandom), pick_word(), pick_word());
        idle_odds = 0;
        for (int n = 0; n < STREAM_ITEMS; n++)
            send_item(LEVEL_W'($urandom_range(0, 2047)));
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_level_extremes();
        test_sector_map();
        test_blend_extremes();
        test_random_phases();
        test_back_to_back();

        // Wait out the pipeline, then wait TAIL_CYCLES more to catch stray results.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** luminance_tint_color_mapper_top: PASSED **");
        end else begin
            $display("** luminance_tint_color_mapper_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> luminance_tint_color_mapper_top.f
src/ltcm_pkg.sv
src/ltcm_sv_gen.sv
src/ltcm_hsv.sv
src/ltcm_blend.sv
src/luminance_tint_color_mapper_top.sv
tb/sv/tb_top.sv
